// ===== src/ep0req_pkg.sv =====
// shared types and constants for the endpoint-0 standard request engine
// transfer structs, request codes, descriptor types and packet sizing
// no dependencies
package ep0req_pkg;

  // packet and buffer sizing
  localparam int unsigned PACKET_BYTES = 8;
  localparam int unsigned BUFFER_BYTES = 256;
  localparam int unsigned REM_W        = $clog2(BUFFER_BYTES + 1);
  localparam int unsigned OFF_W        = 8;
  localparam int unsigned BYTES_W      = 7;

  localparam logic [REM_W-1:0]   PACKET_REM  = REM_W'(PACKET_BYTES);
  localparam logic [BYTES_W-1:0] PACKET_CNT  = BYTES_W'(PACKET_BYTES);
  localparam logic [15:0]        BUFFER_LEN  = 16'(BUFFER_BYTES);

  // configuration register indexes
  localparam logic [1:0] CFG_SELF_POWERED     = 2'd0;
  localparam logic [1:0] CFG_CONFIG_NUMBER    = 2'd1;
  localparam logic [1:0] CFG_IFACE_NUMBER     = 2'd2;
  localparam logic [1:0] CFG_ALT_IFACE_NUMBER = 2'd3;

  // item kinds
  localparam logic KIND_SETUP       = 1'b0;
  localparam logic KIND_IN_COMPLETE = 1'b1;

  // standard request codes
  localparam logic [7:0] REQ_GET_STATUS        = 8'd0;
  localparam logic [7:0] REQ_CLEAR_FEATURE     = 8'd1;
  localparam logic [7:0] REQ_SET_FEATURE       = 8'd3;
  localparam logic [7:0] REQ_SET_ADDRESS       = 8'd5;
  localparam logic [7:0] REQ_GET_DESCRIPTOR    = 8'd6;
  localparam logic [7:0] REQ_GET_CONFIGURATION = 8'd8;
  localparam logic [7:0] REQ_SET_CONFIGURATION = 8'd9;
  localparam logic [7:0] REQ_GET_INTERFACE     = 8'd10;
  localparam logic [7:0] REQ_SET_INTERFACE     = 8'd11;

  // request type field and recipients
  localparam logic [1:0] TYPE_STANDARD = 2'd0;
  localparam logic [4:0] RCPT_DEVICE    = 5'd0;
  localparam logic [4:0] RCPT_INTERFACE = 5'd1;
  localparam logic [4:0] RCPT_ENDPOINT  = 5'd2;

  // feature selectors
  localparam logic [7:0] FEAT_ENDPOINT_HALT  = 8'd0;
  localparam logic [7:0] FEAT_REMOTE_WAKEUP  = 8'd1;
  localparam logic [7:0] FEAT_TEST_MODE      = 8'd2;

  // endpoint numbers
  localparam logic [6:0] EP_CONTROL = 7'd0;
  localparam logic [6:0] EP_ONE     = 7'd1;

  // descriptor types accepted by get descriptor
  localparam logic [7:0] DTYPE_DEVICE        = 8'h01;
  localparam logic [7:0] DTYPE_CONFIGURATION = 8'h02;
  localparam logic [7:0] DTYPE_STRING        = 8'h03;
  localparam logic [7:0] DTYPE_QUALIFIER     = 8'h06;
  localparam logic [7:0] DTYPE_OTHER_SPEED   = 8'h07;
  localparam logic [7:0] DTYPE_HID           = 8'h21;
  localparam logic [7:0] DTYPE_REPORT        = 8'h22;

  // reply sources
  localparam logic [1:0] SRC_STATUS     = 2'd0;
  localparam logic [1:0] SRC_DESCRIPTOR = 2'd1;
  localparam logic [1:0] SRC_CONFIG     = 2'd2;
  localparam logic [1:0] SRC_IFACE      = 2'd3;

  typedef struct packed {
    logic        req_type;
    logic [7:0]  bm_request_type;
    logic [7:0]  b_request;
    logic [7:0]  value_low;
    logic [7:0]  value_high;
    logic [7:0]  index_low;
    logic [15:0] length_requested;
    logic        descriptor_found;
    logic [15:0] descriptor_length;
  } in_item_t;

  typedef struct packed {
    logic               stall_in;
    logic               frame_armed;
    logic [BYTES_W-1:0] frame_bytes;
    logic [OFF_W-1:0]   frame_offset;
    logic [1:0]         response_source;
    logic [15:0]        response_word;
    logic               address_write;
    logic [6:0]         device_address;
    logic               enumerated;
    logic               remote_wakeup_enabled;
    logic               ep1_stalled;
  } out_item_t;

  typedef struct packed {
    logic       self_powered;
    logic [7:0] config_number;
    logic [7:0] iface_number;
    logic [7:0] alt_iface_number;
  } cfg_regs_t;

  typedef struct packed {
    logic wakeup;
    logic ep1_halted;
    logic configured;
  } dev_flags_t;

  typedef struct packed {
    logic             ok;
    logic             has_data;
    logic [REM_W-1:0] reply_len;
    logic [1:0]       src;
    logic [15:0]      word;
    logic             addr_wr;
    logic [6:0]       addr;
    dev_flags_t       flags;
  } dec_res_t;

  typedef struct packed {
    logic [REM_W-1:0] remaining;
    logic             host_wants_more;
    logic             no_more_data;
    logic [OFF_W-1:0] offset;
  } frame_in_t;

  typedef struct packed {
    logic [BYTES_W-1:0] bytes;
    logic [REM_W-1:0]   remaining;
    logic               pending;
    logic               no_more_data;
    logic [OFF_W-1:0]   offset;
  } frame_res_t;

endpackage

// ===== src/ep0req_decode.sv =====
// standard request decoder for one setup packet
// depends on ep0req_pkg
module ep0req_decode (
  input  ep0req_pkg::in_item_t   setup_i,
  input  ep0req_pkg::cfg_regs_t  cfg_i,
  input  ep0req_pkg::dev_flags_t flags_i,
  output ep0req_pkg::dec_res_t   dec_o
);
  import ep0req_pkg::*;

  logic       dir_in;
  logic [1:0] req_kind;
  logic [4:0] rcpt;
  logic [6:0] epn;
  logic       ep_in;
  logic       is_set;
  logic [7:0] vl;
  logic [7:0] vh;
  logic [7:0] il;

  assign dir_in   = setup_i.bm_request_type[7];
  assign req_kind = setup_i.bm_request_type[6:5];
  assign rcpt     = setup_i.bm_request_type[4:0];
  assign epn      = setup_i.index_low[6:0];
  assign ep_in    = setup_i.index_low[7];
  assign vl       = setup_i.value_low;
  assign vh       = setup_i.value_high;
  assign il       = setup_i.index_low;
  assign is_set   = (setup_i.b_request == REQ_SET_FEATURE);

  always_comb begin
    dec_o           = '0;
    dec_o.src       = SRC_STATUS;
    dec_o.flags     = flags_i;
    if (req_kind == TYPE_STANDARD) begin
      case (setup_i.b_request)
        REQ_GET_STATUS: begin
          if (dir_in) begin
            if (rcpt == RCPT_DEVICE) begin
              dec_o.ok   = 1'b1;
              dec_o.word = {14'd0, flags_i.wakeup, cfg_i.self_powered};
            end else if (rcpt == RCPT_INTERFACE) begin
              dec_o.ok = 1'b1;
            end else if (rcpt == RCPT_ENDPOINT) begin
              // endpoint 0 halt is always clear once a setup arrives
              if (epn == EP_CONTROL) begin
                dec_o.ok = 1'b1;
              end else if (epn == EP_ONE && ep_in) begin
                dec_o.ok   = 1'b1;
                dec_o.word = {15'd0, flags_i.ep1_halted};
              end
            end
            dec_o.has_data  = dec_o.ok;
            dec_o.reply_len = REM_W'(2);
          end
        end
        REQ_CLEAR_FEATURE, REQ_SET_FEATURE: begin
          if (is_set || !dir_in) begin
            if (rcpt == RCPT_DEVICE) begin
              if (vl == FEAT_REMOTE_WAKEUP) begin
                dec_o.ok           = 1'b1;
                dec_o.flags.wakeup = is_set;
              end else begin
                dec_o.ok = is_set && (vl == FEAT_TEST_MODE);
              end
            end else if (rcpt == RCPT_ENDPOINT && vl == FEAT_ENDPOINT_HALT) begin
              if (epn == EP_CONTROL) begin
                dec_o.ok = 1'b1;
              end else if (epn == EP_ONE && ep_in) begin
                dec_o.ok               = 1'b1;
                dec_o.flags.ep1_halted = is_set;
              end
            end
          end
        end
        REQ_SET_ADDRESS: begin
          if (!vl[7]) begin
            dec_o.ok      = 1'b1;
            dec_o.addr_wr = 1'b1;
            dec_o.addr    = vl[6:0];
          end
        end
        REQ_GET_DESCRIPTOR: begin
          if ((vh inside {DTYPE_DEVICE, DTYPE_CONFIGURATION, DTYPE_STRING, DTYPE_QUALIFIER,
                          DTYPE_OTHER_SPEED, DTYPE_HID, DTYPE_REPORT})
              && setup_i.descriptor_found) begin
            dec_o.ok = 1'b1;
            // oversize descriptors get a zero-length answer
            if (setup_i.descriptor_length <= BUFFER_LEN) begin
              dec_o.has_data  = 1'b1;
              dec_o.src       = SRC_DESCRIPTOR;
              dec_o.reply_len = setup_i.descriptor_length[REM_W-1:0];
            end
          end
        end
        REQ_GET_CONFIGURATION: begin
          dec_o.ok        = 1'b1;
          dec_o.has_data  = 1'b1;
          dec_o.src       = SRC_CONFIG;
          dec_o.word      = {8'd0, cfg_i.config_number};
          dec_o.reply_len = REM_W'(1);
        end
        REQ_SET_CONFIGURATION: begin
          // a refused configuration still drops the configured flag
          dec_o.flags.configured = |(vl & cfg_i.config_number);
          dec_o.ok               = dec_o.flags.configured;
        end
        REQ_GET_INTERFACE: begin
          if (il == cfg_i.iface_number) begin
            dec_o.ok        = 1'b1;
            dec_o.has_data  = 1'b1;
            dec_o.src       = SRC_IFACE;
            dec_o.word      = {8'd0, cfg_i.alt_iface_number};
            dec_o.reply_len = REM_W'(1);
          end
        end
        REQ_SET_INTERFACE: begin
          dec_o.ok = (il == cfg_i.iface_number) && (vl == cfg_i.alt_iface_number);
        end
        default: begin
          dec_o.ok = 1'b0;
        end
      endcase
    end
  end

endmodule

// ===== src/ep0req_framer.sv =====
// cuts the remaining reply into one IN packet and advances the offset
// depends on ep0req_pkg
module ep0req_framer (
  input  ep0req_pkg::frame_in_t  frame_i,
  output ep0req_pkg::frame_res_t frame_o
);
  import ep0req_pkg::*;

  always_comb begin
    frame_o              = '0;
    frame_o.no_more_data = frame_i.no_more_data;
    if (frame_i.remaining > PACKET_REM) begin
      frame_o.bytes     = PACKET_CNT;
      frame_o.remaining = frame_i.remaining - PACKET_REM;
      frame_o.pending   = 1'b1;
    end else if (frame_i.remaining < PACKET_REM) begin
      frame_o.bytes        = frame_i.remaining[BYTES_W-1:0];
      frame_o.no_more_data = 1'b1;
    end else begin
      // exact packet boundary: a zero-length packet follows if the host wants more
      frame_o.bytes = PACKET_CNT;
      if (frame_i.host_wants_more) begin
        frame_o.pending = 1'b1;
      end else begin
        frame_o.no_more_data = 1'b1;
      end
    end
    frame_o.offset = frame_i.offset + OFF_W'(frame_o.bytes);
  end

endmodule

// ===== src/usb_ep0_standard_request_engine.sv =====
// endpoint-0 standard request engine: input register, decode and framing, result register
// depends on ep0req_pkg, ep0req_decode and ep0req_framer
// an item goes from the input register through decode and framing to the result register
// one item per cycle unless out_ready stalls; decode and framing are combinational
// state flags are registered and feed back into the next item's decode
// reset (synchronous, active low): no items held, flags cleared, config_number 1
module usb_ep0_standard_request_engine (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  ep0req_pkg::in_item_t  in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output ep0req_pkg::out_item_t out_data,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [1:0]            cfg_index,
  input  logic [7:0]            cfg_data
);
  import ep0req_pkg::*;

  // pipeline registers
  logic      in_valid_r;
  in_item_t  in_item_r;
  logic      out_valid_r;
  out_item_t out_item_r;
  logic      advance;
  logic      work;

  // configuration registers
  cfg_regs_t cfg_r;

  // control transfer state
  logic [REM_W-1:0] remaining_r, remaining_nxt;
  logic             no_more_r, no_more_nxt;
  logic [OFF_W-1:0] offset_r, offset_nxt;
  logic             pending_r, pending_nxt;
  logic             wants_more_r, wants_more_nxt;
  logic [1:0]       cur_src_r, cur_src_nxt;
  logic [15:0]      cur_word_r, cur_word_nxt;
  dev_flags_t       flags_r, flags_nxt;
  out_item_t        result_nxt;

  dec_res_t         dec;
  frame_in_t        frame_in;
  frame_res_t       frame_res;
  logic             is_setup;
  logic [15:0]      reply_len16;

  // output register frees when empty or when its transfer completes
  assign advance   = !out_valid_r || out_ready;
  assign in_ready  = !in_valid_r || advance;
  assign work      = in_valid_r && advance;
  assign out_valid = out_valid_r;
  assign out_data  = out_item_r;
  assign cfg_ready = 1'b1;

  assign is_setup    = (in_item_r.req_type == KIND_SETUP);
  assign reply_len16 = 16'(dec.reply_len);

  ep0req_decode u_decode (
    .setup_i (in_item_r),
    .cfg_i   (cfg_r),
    .flags_i (flags_r),
    .dec_o   (dec)
  );

  // framer sees either a fresh reply (setup) or the ongoing one (IN complete)
  always_comb begin
    frame_in = '0;
    if (is_setup) begin
      if (dec.has_data) begin
        if (reply_len16 >= in_item_r.length_requested) begin
          frame_in.remaining = in_item_r.length_requested[REM_W-1:0];
        end else begin
          frame_in.remaining       = dec.reply_len;
          frame_in.host_wants_more = 1'b1;
        end
      end
    end else begin
      frame_in.remaining       = remaining_r;
      frame_in.host_wants_more = wants_more_r;
      frame_in.no_more_data    = no_more_r;
      frame_in.offset          = offset_r;
    end
  end

  ep0req_framer u_framer (
    .frame_i (frame_in),
    .frame_o (frame_res)
  );

  always_comb begin
    remaining_nxt  = remaining_r;
    no_more_nxt    = no_more_r;
    offset_nxt     = offset_r;
    pending_nxt    = pending_r;
    wants_more_nxt = wants_more_r;
    cur_src_nxt    = cur_src_r;
    cur_word_nxt   = cur_word_r;
    flags_nxt      = flags_r;
    result_nxt     = '0;

    if (is_setup) begin
      // every setup starts a fresh control transfer
      remaining_nxt  = '0;
      no_more_nxt    = 1'b0;
      offset_nxt     = '0;
      pending_nxt    = 1'b0;
      wants_more_nxt = 1'b0;
      cur_src_nxt    = SRC_STATUS;
      cur_word_nxt   = '0;
      flags_nxt      = dec.flags;
      if (dec.ok) begin
        if (dec.has_data) begin
          cur_src_nxt  = dec.src;
          cur_word_nxt = dec.word;
        end
        wants_more_nxt            = frame_in.host_wants_more;
        remaining_nxt             = frame_res.remaining;
        no_more_nxt               = frame_res.no_more_data;
        pending_nxt               = frame_res.pending;
        offset_nxt                = frame_res.offset;
        result_nxt.frame_armed    = 1'b1;
        result_nxt.frame_bytes    = frame_res.bytes;
        result_nxt.frame_offset   = frame_in.offset;
        result_nxt.response_source = cur_src_nxt;
        result_nxt.response_word  = cur_word_nxt;
        result_nxt.address_write  = dec.addr_wr;
        result_nxt.device_address = dec.addr;
      end else begin
        result_nxt.stall_in = 1'b1;
      end
    end else if (pending_r) begin
      if (no_more_r) begin
        pending_nxt = 1'b0;
      end else begin
        remaining_nxt              = frame_res.remaining;
        no_more_nxt                = frame_res.no_more_data;
        pending_nxt                = frame_res.pending;
        offset_nxt                 = frame_res.offset;
        result_nxt.frame_armed     = 1'b1;
        result_nxt.frame_bytes     = frame_res.bytes;
        result_nxt.frame_offset    = offset_r;
        result_nxt.response_source = cur_src_r;
        result_nxt.response_word   = cur_word_r;
      end
    end else begin
      // IN complete with nothing outstanding
      result_nxt.stall_in = 1'b1;
    end

    result_nxt.enumerated            = flags_nxt.configured;
    result_nxt.remote_wakeup_enabled = flags_nxt.wakeup;
    result_nxt.ep1_stalled           = flags_nxt.ep1_halted;
  end

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_ready) begin
      in_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      in_item_r <= in_data;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= in_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (work) begin
      out_item_r <= result_nxt;
    end
  end

  // transfer state and device flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      remaining_r  <= '0;
      no_more_r    <= 1'b0;
      offset_r     <= '0;
      pending_r    <= 1'b0;
      wants_more_r <= 1'b0;
      cur_src_r    <= SRC_STATUS;
      cur_word_r   <= '0;
      flags_r      <= '0;
    end else if (work) begin
      remaining_r  <= remaining_nxt;
      no_more_r    <= no_more_nxt;
      offset_r     <= offset_nxt;
      pending_r    <= pending_nxt;
      wants_more_r <= wants_more_nxt;
      cur_src_r    <= cur_src_nxt;
      cur_word_r   <= cur_word_nxt;
      flags_r      <= flags_nxt;
    end
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.self_powered     <= 1'b0;
      cfg_r.config_number    <= 8'd1;
      cfg_r.iface_number     <= 8'd0;
      cfg_r.alt_iface_number <= 8'd0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_SELF_POWERED:     cfg_r.self_powered     <= cfg_data[0];
        CFG_CONFIG_NUMBER:    cfg_r.config_number    <= cfg_data;
        CFG_IFACE_NUMBER:     cfg_r.iface_number     <= cfg_data;
        CFG_ALT_IFACE_NUMBER: cfg_r.alt_iface_number <= cfg_data;
        default: begin
          cfg_r <= cfg_r;
        end
      endcase
    end
  end

endmodule
